[hdl/pamb_pkg.sv]
// Shared types and constants for the per-account priority mailbox.
`default_nettype none
package pamb_pkg;
  localparam int unsigned MaxAccounts = 8;
  localparam int unsigned QueueDepth  = 16;

  localparam logic [1:0] CmdCreate  = 2'd0;
  localparam logic [1:0] CmdRemove  = 2'd1;
  localparam logic [1:0] CmdDeliver = 2'd2;
  localparam logic [1:0] CmdRead    = 2'd3;

  localparam logic [2:0] StCreated  = 3'd0;
  localparam logic [2:0] StExists   = 3'd1;
  localparam logic [2:0] StNoAcct   = 3'd2;
  localparam logic [2:0] StRemoved  = 3'd3;
  localparam logic [2:0] StDelivered = 3'd4;
  localparam logic [2:0] StEmpty    = 3'd5;
  localparam logic [2:0] StMessage  = 3'd6;
  localparam logic [2:0] StFull     = 3'd7;

  // One queue entry as it moves between neighboring cells.
  typedef struct packed {
    logic [7:0]  prio;
    logic [31:0] handle;
  } entry_t;

  // Control broadcast from the mailbox controller to every cell of one row.
  typedef struct packed {
    logic   insert;  // deliver: cells at or past the insert point shift up
    logic   pop;     // read or flush: every cell takes its upper neighbor
    entry_t new_entry;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StFlush,
    StOut
  } state_e;
endpackage
`default_nettype wire

[hdl/per_account_priority_mailbox_top.sv]
// Top level of the per-account priority mailbox.
// Each account owns a row of QUEUE_DEPTH cells that holds its mailbox sorted by
// descending priority, equal priorities first in, first out. A deliver inserts
// in one step (every cell compares itself with the new word and shifts), a read
// pops the row in one step. After a word is accepted, the account lookup is
// registered in StOut, then StExec runs the command and registers the result
// word. The next item is taken in the cycle after the last result word has
// been accepted downstream. A remove adds one result word per queued handle
// (each a row pop) and one for the removed word. Results wait in an output
// register, and a stalled output stalls the flush as well.
`default_nettype none
module per_account_priority_mailbox_top #(
  parameter int unsigned MAX_ACCOUNTS = pamb_pkg::MaxAccounts,
  parameter int unsigned QUEUE_DEPTH  = pamb_pkg::QueueDepth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // command[1:0], account_id[17:2],
                                      // priority_req[25:18], message_handle[57:26], zero
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // status[2:0], message_handle_out[34:3], zero
  output logic        m_axis_tlast    // last
);
  localparam int unsigned SW = (MAX_ACCOUNTS > 1) ? $clog2(MAX_ACCOUNTS) : 1;
  localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1);

  pamb_pkg::state_e state_q, state_d;
  logic [1:0]  cmd_q;
  logic [15:0] key_q;
  logic [7:0]  pri_q;
  logic [31:0] hdl_q;

  logic [MAX_ACCOUNTS-1:0] valid_q;
  logic [15:0]             akey_q [MAX_ACCOUNTS];
  logic [LW-1:0]           len_q  [MAX_ACCOUNTS];

  logic          hit_q, free_any_q;
  logic [SW-1:0] slot_q, free_q;

  logic [2:0]  ost_q;
  logic [31:0] ohdl_q;
  logic        olast_q, ovalid_q;

  pamb_pkg::cell_ctrl_t ctrl [MAX_ACCOUNTS];
  pamb_pkg::entry_t     head [MAX_ACCOUNTS];

  logic [LW-1:0] cur_len;
  assign cur_len = len_q[slot_q];

  for (genvar a = 0; a < MAX_ACCOUNTS; a++) begin : g_row
    logic sel;
    assign sel = hit_q && (slot_q == SW'(a));
    always_comb begin
      ctrl[a].new_entry.prio   = pri_q;
      ctrl[a].new_entry.handle = hdl_q;
      ctrl[a].insert = sel && (state_q == pamb_pkg::StExec) &&
                       (cmd_q == pamb_pkg::CmdDeliver) && (cur_len < LW'(QUEUE_DEPTH));
      ctrl[a].pop    = sel && (((state_q == pamb_pkg::StExec) &&
                       (cmd_q == pamb_pkg::CmdRead) && (cur_len != '0)) ||
                       ((state_q == pamb_pkg::StFlush) && (cur_len != '0) &&
                       (!ovalid_q || m_axis_tready)));
    end
    pamb_row #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_row (
      .clk_i, .rst_ni, .ctrl_i(ctrl[a]), .len_i(len_q[a]), .head_o(head[a])
    );
  end

  // Lookup of the key and the lowest free slot, registered for the next stage.
  logic          hit_d, free_any_d;
  logic [SW-1:0] slot_d, free_d;
  always_comb begin
    hit_d = 1'b0; slot_d = '0; free_any_d = 1'b0; free_d = '0;
    for (int s = MAX_ACCOUNTS - 1; s >= 0; s--) begin
      if (valid_q[s] && akey_q[s] == key_q) begin
        hit_d = 1'b1; slot_d = SW'(s);
      end
      if (!valid_q[s]) begin
        free_any_d = 1'b1; free_d = SW'(s);
      end
    end
  end

  logic out_free;
  assign out_free = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == pamb_pkg::StIdle) && !ovalid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pamb_pkg::StIdle: if (s_axis_tvalid && s_axis_tready) state_d = pamb_pkg::StOut;
      pamb_pkg::StOut:  state_d = pamb_pkg::StExec;
      pamb_pkg::StExec: begin
        if (hit_q && cmd_q == pamb_pkg::CmdRemove) state_d = pamb_pkg::StFlush;
        else state_d = pamb_pkg::StIdle;
      end
      pamb_pkg::StFlush: if (out_free && cur_len == '0) state_d = pamb_pkg::StIdle;
      default: state_d = pamb_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pamb_pkg::StIdle;
      valid_q <= '0;
      ovalid_q <= 1'b0;
      olast_q <= 1'b0;
      ost_q <= '0;
      ohdl_q <= '0;
      hit_q <= 1'b0;
      free_any_q <= 1'b0;
      slot_q <= '0;
      free_q <= '0;
      for (int s = 0; s < MAX_ACCOUNTS; s++) begin
        len_q[s] <= '0;
        akey_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (m_axis_tready) ovalid_q <= 1'b0;
      if (state_q == pamb_pkg::StOut) begin
        hit_q <= hit_d; slot_q <= slot_d; free_any_q <= free_any_d; free_q <= free_d;
      end
      if (state_q == pamb_pkg::StExec) begin
        ovalid_q <= 1'b1; olast_q <= 1'b1; ohdl_q <= '0;
        if (cmd_q == pamb_pkg::CmdCreate) begin
          if (hit_q) ost_q <= pamb_pkg::StExists;
          else if (!free_any_q) ost_q <= pamb_pkg::StFull;
          else begin
            ost_q <= pamb_pkg::StCreated;
            valid_q[free_q] <= 1'b1;
            akey_q[free_q] <= key_q;
            len_q[free_q] <= '0;
          end
        end else if (!hit_q) begin
          ost_q <= pamb_pkg::StNoAcct;
        end else begin
          unique case (cmd_q)
            pamb_pkg::CmdRemove: ovalid_q <= 1'b0;
            pamb_pkg::CmdDeliver: begin
              if (cur_len >= LW'(QUEUE_DEPTH)) ost_q <= pamb_pkg::StFull;
              else begin
                ost_q <= pamb_pkg::StDelivered;
                len_q[slot_q] <= cur_len + LW'(1);
              end
            end
            default: begin
              if (cur_len == '0) ost_q <= pamb_pkg::StEmpty;
              else begin
                ost_q <= pamb_pkg::StMessage;
                ohdl_q <= head[slot_q].handle;
                len_q[slot_q] <= cur_len - LW'(1);
              end
            end
          endcase
        end
      end
      if (state_q == pamb_pkg::StFlush && out_free) begin
        ovalid_q <= 1'b1;
        if (cur_len != '0) begin
          ost_q <= pamb_pkg::StMessage; ohdl_q <= head[slot_q].handle; olast_q <= 1'b0;
          len_q[slot_q] <= cur_len - LW'(1);
        end else begin
          ost_q <= pamb_pkg::StRemoved; ohdl_q <= '0; olast_q <= 1'b1;
          valid_q[slot_q] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tdata[1:0];
      key_q <= s_axis_tdata[17:2];
      pri_q <= s_axis_tdata[25:18];
      hdl_q <= s_axis_tdata[57:26];
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'd0, ohdl_q, ost_q};
  assign m_axis_tlast  = olast_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_len <= LW'(QUEUE_DEPTH)) else $error("queue length out of range");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != pamb_pkg::StIdle) |-> !s_axis_tready) else $error("accept while busy");
  a_flush_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pamb_pkg::StFlush) |-> hit_q && valid_q[slot_q])
    else $error("flush without account");
endmodule
`default_nettype wire

[hdl/pamb_cell.sv]
// One queue cell: holds an entry and trades it with its neighbors.
`default_nettype none
module pamb_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  pamb_pkg::cell_ctrl_t ctrl_i,
  input  wire                 occupied_i,   // this cell is below the queue length
  input  wire                 below_ins_i,  // lower neighbor stays in place on insert
  input  pamb_pkg::entry_t    lower_i,      // entry of the lower neighbor
  input  pamb_pkg::entry_t    upper_i,      // entry of the upper neighbor
  output pamb_pkg::entry_t    entry_o,
  output logic                keep_o        // this cell stays in place on insert
);
  pamb_pkg::entry_t entry_q, entry_d;

  // Equal priorities stay ahead of a new entry, which keeps the order stable.
  assign keep_o = occupied_i && (entry_q.prio >= ctrl_i.new_entry.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.pop) begin
      entry_d = upper_i;
    end else if (ctrl_i.insert && !keep_o) begin
      entry_d = below_ins_i ? ctrl_i.new_entry : lower_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
endmodule
`default_nettype wire

[hdl/pamb_row.sv]
// One account's mailbox: a row of cells ordered by descending priority.
`default_nettype none
module pamb_row #(
  parameter int unsigned QUEUE_DEPTH = pamb_pkg::QueueDepth
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  pamb_pkg::cell_ctrl_t ctrl_i,
  input  wire [$clog2(QUEUE_DEPTH+1)-1:0] len_i,
  output pamb_pkg::entry_t     head_o
);
  pamb_pkg::entry_t ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keep;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    pamb_pkg::entry_t lower, upper;
    logic below;
    if (g == 0) begin : g_first
      assign lower = ctrl_i.new_entry;
      assign below = 1'b1;
    end else begin : g_mid
      assign lower = ent[g-1];
      assign below = keep[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_up
      assign upper = ent[g+1];
    end
    pamb_cell u_cell (
      .clk_i,
      .rst_ni,
      .ctrl_i,
      .occupied_i  ({1'b0, len_i} > ($clog2(QUEUE_DEPTH+1)+1)'(g)),
      .below_ins_i (below),
      .lower_i     (lower),
      .upper_i     (upper),
      .entry_o     (ent[g]),
      .keep_o      (keep[g])
    );
  end

  assign head_o = ent[0];
endmodule
`default_nettype wire
